// ----- rtl/sgau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgau_pkg
// Beat types and register/request codes shared by the gradient update unit.
// ----------------------------------------------------------------------------
package sgau_pkg;

  typedef enum logic [1:0] {
    REQ_ROW_START = 2'd0,
    REQ_SAMPLE    = 2'd1,
    REQ_APPLY     = 2'd2,
    REQ_NONE      = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    CFG_BOTEV_MODE  = 3'd0,
    CFG_SVI_FACTOR  = 3'd1,
    CFG_WEIGHT_PREC = 3'd2,
    CFG_BIAS_PREC   = 3'd3,
    CFG_KAPPA       = 3'd4,
    CFG_ETA_SCALED  = 3'd5,
    CFG_DELAY_T     = 3'd6,
    CFG_UNUSED      = 3'd7
  } cfg_index_t;

  localparam int CFG_DATA_W = 32;
  localparam int CLASS_W    = 10;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [CLASS_W-1:0] class_index;
    logic signed [31:0] sample_value;
    logic signed [31:0] botev_value;
    logic signed [31:0] param_value;
    logic [31:0]        history_value;
    logic               is_bias;
  } sgau_in_t;

  typedef struct packed {
    logic [CLASS_W-1:0] out_class;
    logic signed [31:0] new_param;
    logic [31:0]        new_history;
    logic               changed;
  } sgau_out_t;

endpackage

// ----- rtl/sgau_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgau_in_if
// Valid/ready channel carrying request beats into the update unit.
// ----------------------------------------------------------------------------
interface sgau_in_if;
  import sgau_pkg::*;
  logic     valid;
  logic     ready;
  sgau_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/sgau_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgau_out_if
// Valid/ready channel carrying result beats out of the update unit.
// ----------------------------------------------------------------------------
interface sgau_out_if;
  import sgau_pkg::*;
  logic      valid;
  logic      ready;
  sgau_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/sgau_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgau_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sgau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- rtl/sparse_gradient_adaptive_update_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_gradient_adaptive_update_unit
// Per-class gradient accumulator with an adaptive step-size parameter update.
// ----------------------------------------------------------------------------
// One request is processed at a time. After reset the unit sweeps the
// gradient memory to zero, one entry per cycle, before the first request
// is accepted. A row start only latches its value, or in botev mode does
// one read-modify-write pass on the single gradient memory; a sample does
// one pass in botev mode and two passes otherwise. An apply with a zero
// gradient goes straight to the output; a nonzero gradient runs through
// the 24-step square root and the 64-step divider. A finished result
// waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module sparse_gradient_adaptive_update_unit #(
  parameter int NUM_CLASSES = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  sgau_in_if.sink                      in_ch,
  sgau_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  sgau_pkg::cfg_index_t         cfg_index,
  input  logic [sgau_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sgau_pkg::*;

  localparam int AW = $clog2(NUM_CLASSES);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MUL, S_ACC, S_RMW_RD, S_RMW_WR, S_AP_RD, S_AP_WR,
    S_GSVI, S_PRIOR, S_GSUB, S_SQ, S_MIXLO, S_MIX1, S_MIX2, S_MIX3, S_MIX4,
    S_HSAT, S_SQRT, S_DEN, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state_r;

  logic        botev_r;
  logic [31:0] svi_r, wprec_r, bprec_r, eta_r, delay_r;
  logic [16:0] kappa_r;

  sgau_in_t           item_r;
  logic signed [31:0] lat_x_r;
  logic [CLASS_W-1:0] lat_pos_r;
  logic [CLASS_W-1:0] addr_r;
  logic signed [32:0] delta_r;
  logic signed [31:0] p_r;
  logic               second_r;
  logic [AW-1:0]      clr_r;

  logic signed [31:0] g_r;
  logic signed [67:0] prod_r;
  logic [46:0]        sq_r;
  logic signed [63:0] num_r;
  logic [64:0]        mix_r;
  logic [31:0]        newh_r;
  logic [47:0]        rad_r;
  logic [26:0]        srem_r;
  logic [23:0]        root_r;
  logic [5:0]         cnt_r;
  logic [32:0]        den_r;
  logic [63:0]        mag_r;
  logic [33:0]        drem_r;
  logic               neg_r;
  sgau_out_t          res_r;
  logic               out_valid_r;
  sgau_out_t          out_data_r;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qround(input logic signed [67:0] p);
    logic signed [67:0] t;
    t = (p + 68'sd32768) >>> 16;
    if (t > 68'sd2147483647) return 32'sh7fffffff;
    if (t < -68'sd2147483648) return 32'sh80000000;
    return t[31:0];
  endfunction

  function automatic logic in_rng(input logic [CLASS_W-1:0] c);
    return 17'(c) < 17'(NUM_CLASSES);
  endfunction

  // Kappa above one acts as one
  logic [16:0] k_eff;
  assign k_eff = (kappa_r > 17'd65536) ? 17'd65536 : kappa_r;

  logic [31:0] prec;
  assign prec = item_r.is_bias ? bprec_r : wprec_r;

  // Shared multiplier
  logic signed [33:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL: begin
        mul_a = (item_r.req_type == REQ_ROW_START) ?
                34'sd65536 - 34'(item_r.botev_value) : 34'(lat_x_r);
        mul_b = 34'(item_r.sample_value);
      end
      S_GSVI: begin
        mul_a = 34'(g_r);
        mul_b = $signed({2'b00, svi_r});
      end
      S_PRIOR: begin
        mul_a = 34'(item_r.param_value);
        mul_b = $signed({2'b00, prec});
      end
      S_SQ: begin
        mul_a = 34'(g_r);
        mul_b = 34'(g_r);
      end
      S_MIXLO: begin
        mul_a = $signed({2'b00, eta_r});
        mul_b = 34'(g_r);
      end
      S_MIX1: begin
        mul_a = $signed({17'd0, k_eff});
        mul_b = $signed({10'd0, sq_r[23:0]});
      end
      S_MIX2: begin
        mul_a = $signed({17'd0, k_eff});
        mul_b = $signed({11'd0, sq_r[46:24]});
      end
      S_MIX3: begin
        mul_a = $signed({17'd0, 17'd65536 - k_eff});
        mul_b = $signed({2'b00, item_r.history_value});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Gradient memory
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;
  logic [16:0]      addr_ext;
  logic signed [31:0] rmw_sum;

  assign addr_ext  = 17'(addr_r);
  assign ram_raddr = addr_ext[AW-1:0];
  assign rmw_sum   = sat34(34'($signed(ram_rdata)) + 34'(delta_r));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_ext[AW-1:0];
    ram_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      S_RMW_WR: begin
        ram_we    = in_rng(addr_r);
        ram_wdata = rmw_sum;
      end
      S_AP_WR: ram_we = in_rng(addr_r);
      default: ram_we = 1'b0;
    endcase
  end

  sgau_ram #(.WIDTH(32), .DEPTH(NUM_CLASSES)) u_grad_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Iterative square root and divider steps
  logic [26:0] s_shift, s_trial;
  logic [33:0] d_shift;
  logic        d_ge;
  assign s_shift = {srem_r[24:0], rad_r[47:46]};
  assign s_trial = {1'b0, root_r, 2'b01};
  assign d_shift = {drem_r[32:0], mag_r[63]};
  assign d_ge    = d_shift >= {1'b0, den_r};

  logic [32:0]        q_clamp;
  logic signed [33:0] q_signed;
  logic signed [31:0] step;
  always_comb begin
    q_clamp  = (mag_r > 64'h8000_0000) ? 33'h0_8000_0000 : mag_r[32:0];
    q_signed = neg_r ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
    if (den_r == '0) begin
      step = g_r[31] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      step = sat34(q_signed);
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  logic in_beat;
  assign in_beat = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      lat_x_r     <= '0;
      lat_pos_r   <= '0;
      second_r    <= 1'b0;
      botev_r     <= 1'b0;
      svi_r       <= 32'd65536;
      wprec_r     <= '0;
      bprec_r     <= '0;
      kappa_r     <= 17'd65536;
      eta_r       <= 32'd65536;
      delay_r     <= 32'd65536;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BOTEV_MODE:  botev_r <= cfg_wdata[0];
          CFG_SVI_FACTOR:  svi_r   <= cfg_wdata;
          CFG_WEIGHT_PREC: wprec_r <= cfg_wdata;
          CFG_BIAS_PREC:   bprec_r <= cfg_wdata;
          CFG_KAPPA:       kappa_r <= cfg_wdata[16:0];
          CFG_ETA_SCALED:  eta_r   <= cfg_wdata;
          CFG_DELAY_T:     delay_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(NUM_CLASSES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_beat) begin
            item_r <= in_ch.data;
            addr_r <= in_ch.data.class_index;
            unique case (in_ch.data.req_type)
              REQ_ROW_START: begin
                lat_x_r   <= in_ch.data.sample_value;
                lat_pos_r <= in_ch.data.class_index;
                if (botev_r) begin
                  state_r <= S_MUL;
                end
              end
              REQ_SAMPLE: state_r <= S_MUL;
              REQ_APPLY:  state_r <= S_AP_RD;
              default: ;
            endcase
          end
        end
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          p_r <= qround(prod_r);
          if (item_r.req_type == REQ_SAMPLE && !botev_r) begin
            delta_r  <= 33'(qround(prod_r));
            addr_r   <= lat_pos_r;
            second_r <= 1'b1;
          end else if (item_r.req_type == REQ_SAMPLE) begin
            delta_r  <= -33'(qround(prod_r));
            second_r <= 1'b0;
          end else begin
            delta_r  <= 33'(qround(prod_r));
            second_r <= 1'b0;
          end
          state_r <= S_RMW_RD;
        end
        S_RMW_RD: state_r <= S_RMW_WR;
        S_RMW_WR: begin
          if (second_r) begin
            second_r <= 1'b0;
            addr_r   <= item_r.class_index;
            delta_r  <= -33'(p_r);
            state_r  <= S_RMW_RD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_AP_RD: state_r <= S_AP_WR;
        S_AP_WR: begin
          g_r <= in_rng(addr_r) ? $signed(ram_rdata) : 32'sd0;
          res_r.out_class   <= item_r.class_index;
          res_r.new_param   <= item_r.param_value;
          res_r.new_history <= item_r.history_value;
          res_r.changed     <= 1'b0;
          if (!in_rng(addr_r) || ram_rdata == '0) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_GSVI;
          end
        end
        S_GSVI:  state_r <= S_PRIOR;
        S_PRIOR: begin
          g_r     <= qround(prod_r);
          state_r <= S_GSUB;
        end
        S_GSUB: begin
          if (prec != '0) begin
            g_r <= sat34(34'(g_r) - 34'(qround(prod_r)));
          end
          state_r <= S_SQ;
        end
        S_SQ: state_r <= S_MIXLO;
        S_MIXLO: begin
          sq_r    <= 47'((prod_r[63:0] + 64'd32768) >> 16);
          state_r <= S_MIX1;
        end
        S_MIX1: begin
          num_r   <= prod_r[63:0];
          state_r <= S_MIX2;
        end
        S_MIX2: begin
          mix_r   <= prod_r[64:0];
          state_r <= S_MIX3;
        end
        S_MIX3: begin
          mix_r   <= mix_r + (prod_r[64:0] << 24);
          state_r <= S_MIX4;
        end
        S_MIX4: begin
          mix_r   <= mix_r + prod_r[64:0] + 65'd32768;
          state_r <= S_HSAT;
        end
        S_HSAT: begin
          if (mix_r[64:48] != '0) begin
            newh_r <= 32'hffff_ffff;
            rad_r  <= {32'hffff_ffff, 16'd0};
          end else begin
            newh_r <= mix_r[47:16];
            rad_r  <= {mix_r[47:16], 16'd0};
          end
          srem_r  <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          rad_r <= {rad_r[45:0], 2'b00};
          if (s_shift >= s_trial) begin
            srem_r <= s_shift - s_trial;
            root_r <= {root_r[22:0], 1'b1};
          end else begin
            srem_r <= s_shift;
            root_r <= {root_r[22:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'd23) begin
            state_r <= S_DEN;
          end
        end
        S_DEN: begin
          den_r   <= {1'b0, delay_r} + {9'd0, root_r};
          mag_r   <= num_r[63] ? 64'(-num_r) : 64'(num_r);
          neg_r   <= num_r[63];
          drem_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          drem_r <= d_ge ? d_shift - {1'b0, den_r} : d_shift;
          mag_r  <= {mag_r[62:0], d_ge};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == 6'd63) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          res_r.new_param   <= sat34(34'(item_r.param_value) + 34'(step));
          res_r.new_history <= newh_r;
          res_r.changed     <= 1'b1;
          state_r           <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ram_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !ram_we)
    else $error("gradient memory written while idle");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

  a_apply_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AP_WR && ram_we) |-> ram_wdata == '0)
    else $error("applied entry not cleared");

  a_second_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && item_r.req_type == REQ_SAMPLE && !botev_r) |=> second_r)
    else $error("positive scatter lost");
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sparse gradient adaptive update unit. A table
// of directed requests runs first, then register phases with random row,
// sample and apply sequences. A bit-accurate gradient and update predictor
// supplies expected beats not given by table rows; all compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import sgau_pkg::*;

  localparam int NCLS       = 1024;
  localparam int WDOG_LIMIT = 20000;
  localparam int SETTLE     = 200;
  localparam int NPHASE     = 8;

  typedef struct {
    sgau_in_t  req;
    bit        typed;
    sgau_out_t res;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sgau_in_if  in_ch ();
  sgau_out_if out_ch ();

  sparse_gradient_adaptive_update_unit #(.NUM_CLASSES(NCLS)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  longint    grad_mem [NCLS];
  longint    row_x;
  int        row_pos;
  bit        r_botev;
  longint    r_svi, r_wprec, r_bprec, r_kappa, r_eta, r_delay;

  sgau_out_t expected_results [$];
  row_t      stim_table [$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        tx_idle, rx_idle;
  bit        hold_req;
  int        hold_cnt = 0;
  int        sent;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat32((a * b + 32768) >>> 16);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void reset_model();
    foreach (grad_mem[i]) grad_mem[i] = 0;
    row_x = 0; row_pos = 0;
    r_botev = 0; r_svi = 65536; r_wprec = 0; r_bprec = 0;
    r_kappa = 65536; r_eta = 65536; r_delay = 65536;
  endfunction

  function automatic bit predict_update(sgau_in_t r, output sgau_out_t o);
    longint sv, bv, prm, g, p, num, delta, newp;
    longint unsigned hist, k, sq, newh, den, mag, q;
    int cls;
    sv = longint'(r.sample_value);
    bv = longint'(r.botev_value);
    prm = longint'(r.param_value);
    hist = longint'(r.history_value) & 64'hFFFF_FFFF;
    cls = int'(r.class_index);
    o = '0;
    case (req_type_t'(r.req_type))
      REQ_ROW_START: begin
        row_x = sv;
        row_pos = cls;
        if (r_botev) grad_mem[cls] = sat32(grad_mem[cls] + qmul(65536 - bv, sv));
        return 0;
      end
      REQ_SAMPLE: begin
        p = qmul(row_x, sv);
        if (!r_botev) grad_mem[row_pos] = sat32(grad_mem[row_pos] + p);
        grad_mem[cls] = sat32(grad_mem[cls] - p);
        return 0;
      end
      REQ_APPLY: begin
        g = grad_mem[cls];
        grad_mem[cls] = 0;
        newh = hist;
        newp = prm;
        o.changed = 1'b0;
        if (g != 0) begin
          k = (r_kappa > 65536) ? 65536 : r_kappa;
          g = qmul(g, r_svi);
          if (r.is_bias && r_bprec != 0) g = sat32(g - qmul(prm, r_bprec));
          if (!r.is_bias && r_wprec != 0) g = sat32(g - qmul(prm, r_wprec));
          sq = (longint'(g * g) + 32768) >> 16;
          newh = (k * sq + (65536 - k) * hist + 32768) >> 16;
          if (newh > 64'hFFFF_FFFF) newh = 64'hFFFF_FFFF;
          den = longint'(r_delay) + int_sqrt(newh << 16);
          num = r_eta * g;
          if (den == 0) begin
            delta = (g < 0) ? -64'sd2147483648 : 64'sd2147483647;
          end else begin
            mag = (num < 0) ? -num : num;
            q = mag / den;
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            delta = (num < 0) ? -longint'(q) : longint'(q);
            delta = sat32(delta);
          end
          newp = sat32(prm + delta);
          o.changed = 1'b1;
        end
        o.out_class = r.class_index;
        o.new_param = newp[31:0];
        o.new_history = newh[31:0];
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic sgau_in_t make_req(req_type_t t, int cls, logic [31:0] sv,
                                         logic [31:0] bv, logic [31:0] pv,
                                         logic [31:0] hv, bit bias);
    sgau_in_t r;
    r.req_type = t; r.class_index = cls[CLASS_W-1:0];
    r.sample_value = sv; r.botev_value = bv; r.param_value = pv;
    r.history_value = hv; r.is_bias = bias;
    return r;
  endfunction

  function automatic void add_row(sgau_in_t r, bit typed, bit chg);
    row_t e;
    e.req = r;
    e.typed = typed;
    e.res.out_class = r.class_index;
    e.res.new_param = r.param_value;
    e.res.new_history = r.history_value;
    e.res.changed = chg;
    stim_table.push_back(e);
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 3);
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic int rand_cls();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, NCLS - 1);
  endfunction

  function automatic logic [31:0] rand_hist();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return $urandom;
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  task automatic send_req(sgau_in_t r, bit typed, sgau_out_t typed_res);
    sgau_out_t o;
    bit has;
    while ($urandom_range(0, 99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    do @(posedge clk); while (!in_ch.ready);
    has = predict_update(r, o);
    if (has) expected_results.push_back(typed ? typed_res : o);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, longint unsigned v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_BOTEV_MODE:  r_botev = v[0];
      CFG_SVI_FACTOR:  r_svi = v & 64'hFFFF_FFFF;
      CFG_WEIGHT_PREC: r_wprec = v & 64'hFFFF_FFFF;
      CFG_BIAS_PREC:   r_bprec = v & 64'hFFFF_FFFF;
      CFG_KAPPA:       r_kappa = v & 64'h1FFFF;
      CFG_ETA_SCALED:  r_eta = v & 64'hFFFF_FFFF;
      CFG_DELAY_T:     r_delay = v & 64'hFFFF_FFFF;
      default: ;
    endcase
  endtask

  function automatic longint unsigned pick_reg(int w);
    case ($urandom_range(0, 3))
      0: return 65536;
      1: return $urandom_range(0, 32'h0004_0000);
      2: return (w == 17) ? $urandom_range(0, 65536) : 0;
      default: return (w == 17) ? $urandom_range(0, 32'h1FFFF) : $urandom;
    endcase
  endfunction

  task automatic setup_phase(int ph);
    longint unsigned v [7];
    case (ph)
      0: v = '{1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1FFFF,
               32'hFFFF_FFFF, 0};
      1: v = '{0, 0, 0, 0, 0, 0, 0};
      2: v = '{1, 65536, 0, 0, 65536, 65536, 0};
      default: v = '{$urandom_range(0, 1), pick_reg(32), pick_reg(32), pick_reg(32),
                     pick_reg(17), pick_reg(32), pick_reg(32)};
    endcase
    for (int i = 0; i < 7; i++) write_reg(cfg_index_t'(i), v[i]);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    sgau_in_t r;
    sgau_out_t dummy;
    int cnt, pos;
    cnt = 0;
    dummy = '0;
    while (cnt < n) begin
      if ($urandom_range(0, 3) != 0) begin
        pos = rand_cls();
        r = make_req(REQ_ROW_START, pos, rand_val(), rand_val(), $urandom, $urandom,
                     $urandom_range(0, 1));
        send_req(r, 0, dummy);
        repeat ($urandom_range(1, 4)) begin
          r = make_req(REQ_SAMPLE, ($urandom_range(0, 4) == 0) ? pos : rand_cls(),
                       rand_val(), $urandom, $urandom, $urandom, $urandom_range(0, 1));
          send_req(r, 0, dummy);
          cnt++;
        end
        repeat ($urandom_range(1, 3)) begin
          r = make_req(REQ_APPLY, ($urandom_range(0, 2) == 0) ? pos : rand_cls(),
                       $urandom, $urandom, rand_val(), rand_hist(), $urandom_range(0, 1));
          send_req(r, 0, dummy);
          cnt++;
        end
        cnt++;
      end else begin
        r = make_req(req_type_t'($urandom_range(0, 3)), $urandom_range(0, NCLS - 1),
                     $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
        send_req(r, 0, dummy);
        if (r.req_type != REQ_NONE) cnt++;
      end
    end
  endtask

  // receiver
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 1) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_cnt == 1) hold_cnt <= -1;
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // result checker
  always @(posedge clk) begin
    sgau_out_t e, a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, a);
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        if (a.out_class !== e.out_class) begin
          $display("%0t: out_class exp %0d got %0d", $time, e.out_class, a.out_class);
          mismatches++;
        end
        if (a.new_param !== e.new_param) begin
          $display("%0t: new_param exp %h got %h", $time, e.new_param, a.new_param);
          mismatches++;
        end
        if (a.new_history !== e.new_history) begin
          $display("%0t: new_history exp %h got %h", $time, e.new_history, a.new_history);
          mismatches++;
        end
        if (a.changed !== e.changed) begin
          $display("%0t: changed exp %b got %b", $time, e.changed, a.changed);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sgau_out_t dummy;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BOTEV_MODE;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    hold_req = 0;
    sent = 0;
    tx_idle = 37;
    rx_idle = 66;
    dummy = '0;
    reset_model();

    add_row(make_req(REQ_APPLY, 0, '0, '0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0), 1, 0);
    add_row(make_req(REQ_APPLY, NCLS - 1, '1, '1, 32'h8000_0000, 32'h0, 1), 1, 0);
    add_row(make_req(REQ_NONE, NCLS - 1, '1, '1, '1, '1, 1), 0, 0);
    add_row(make_req(REQ_ROW_START, 3, 32'h7FFF_FFFF, '0, '0, '0, 0), 0, 0);
    add_row(make_req(REQ_SAMPLE, 7, 32'h8000_0000, '0, '0, '0, 0), 0, 0);
    add_row(make_req(REQ_SAMPLE, 3, 32'h0001_0000, '0, '0, '0, 0), 0, 0);
    add_row(make_req(REQ_APPLY, 3, '0, '0, 32'h0001_0000, 32'h0002_0000, 0), 0, 0);
    add_row(make_req(REQ_APPLY, 7, '0, '0, 32'h8000_0000, 32'hFFFF_FFFF, 1), 0, 0);
    add_row(make_req(REQ_APPLY, 7, '0, '0, 32'h1234_5678, 32'h0000_0100, 0), 1, 0);
    add_row(make_req(REQ_ROW_START, NCLS - 1, 32'h8000_0000, '1, '0, '0, 1), 0, 0);
    add_row(make_req(REQ_SAMPLE, 0, 32'h7FFF_FFFF, '0, '0, '0, 1), 0, 0);
    add_row(make_req(REQ_SAMPLE, 5, 32'h0000_0001, '0, '0, '0, 1), 0, 0);
    add_row(make_req(REQ_APPLY, NCLS - 1, '0, '0, 32'h7FFF_FFFF, 32'h0, 1), 0, 0);
    add_row(make_req(REQ_APPLY, 0, '0, '0, 32'h0, 32'h0, 0), 0, 0);
    add_row(make_req(REQ_APPLY, 5, '0, '0, 32'hFFFF_0000, 32'h0, 0), 0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) send_req(stim_table[i].req, stim_table[i].typed,
                                     stim_table[i].res);
    drain();

    for (int ph = 0; ph < NPHASE; ph++) begin
      case (ph * 3 / NPHASE)
        0: begin tx_idle = 37; rx_idle = 66; end
        1: begin tx_idle = 66; rx_idle = 37; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      setup_phase(ph);
      if (ph == 1) hold_req = 1;
      random_phase(40);
      hold_req = 0;
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (expected_results.size() != 0) @(posedge clk);
      random_phase(35);
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
